@@ src/arp_pkg.sv @@
// Package for the arpeggio phase accumulator: field widths, reset constants,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package arp_pkg;

    localparam int NUM_KEYS_DEF   = 12;
    localparam int PHASE_BITS_DEF = 32;

    localparam int KEY_IDX_W = 4;
    localparam int STEP_W    = 32;
    localparam int VOL_W     = 4;
    localparam int DWELL_W   = 7;
    localparam int SAMPLE_W  = 8;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 7'd25;
    localparam logic [VOL_W-1:0]   FULL_VOLUME = 4'd8;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic write;     // store step_size at key_index
        logic start;     // advance dwell divider, latch volume, step key pointer on wrap
        logic advance;   // move key pointer to next key
        logic add;       // add current key's step to phase
        logic load_out;  // compute sample into output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic any;       // some stored step is nonzero
        logic hit;       // step at key pointer is nonzero
        logic out_busy;  // output register holds a result not yet taken
    } status_t;

endpackage

@@ src/arp_ctrl.sv @@
// Controller state machine for the arpeggio phase accumulator.
// Depends on arp_pkg (state_t, cmd_t, status_t, FUNC_* codes).
module arp_ctrl
    import arp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    func,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // One table entry per cycle until a held key is found; no walk when no key is held
                if (!status.any)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.hit)
                begin
                    cmd.add    = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/arp_datapath.sv @@
// Datapath of the arpeggio phase accumulator: step table, dwell divider,
// key pointer, phase accumulator and output register. Depends on arp_pkg.
module arp_datapath
    import arp_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [KEY_IDX_W-1:0] key_index,
    input  logic [STEP_W-1:0]    step_size,
    input  logic [VOL_W-1:0]     volume,
    input  logic                 cfg_we,
    input  logic [DWELL_W-1:0]   cfg_wdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SAMPLE_W-1:0]  sample_out
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    logic [STEP_W-1:0]     step_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0]   nz_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [KEY_W-1:0]      ptr_reg;
    logic [DWELL_W-1:0]    cnt_reg;
    logic [DWELL_W-1:0]    dwell_reg;
    logic [VOL_W-1:0]      vol_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   sample_reg;

    logic [DWELL_W-1:0]    cnt_inc;
    logic [DWELL_W-1:0]    cnt_next;
    logic [KEY_W-1:0]      ptr_succ;
    logic                  key_ok;
    logic [VOL_W-1:0]      shift_amt;
    logic signed [SAMPLE_W-1:0] centered;
    logic signed [SAMPLE_W-1:0] scaled;
    logic [SAMPLE_W-1:0]   top_byte;

    assign key_ok   = (int'(key_index) < NUM_KEYS);
    assign ptr_succ = (ptr_reg == LAST_KEY) ? '0 : ptr_reg + KEY_W'(1);
    assign cnt_inc  = cnt_reg + DWELL_W'(1);
    assign cnt_next = (cnt_inc >= dwell_reg) ? '0 : cnt_inc;

    assign status.any      = |nz_reg;
    assign status.hit      = nz_reg[ptr_reg];
    assign status.out_busy = out_valid_reg && !out_ready;

    // Sample: (top byte - 128) >>> (8 - volume) + 128, volume clamped to full
    assign top_byte  = phase_reg[PHASE_BITS-1 -: SAMPLE_W];
    assign shift_amt = (vol_reg > FULL_VOLUME) ? '0 : FULL_VOLUME - vol_reg;
    assign centered  = {~top_byte[SAMPLE_W-1], top_byte[SAMPLE_W-2:0]};
    assign scaled    = centered >>> shift_amt;

    // Table payload; nz_reg marks which entries hold a nonzero step
    always_ff @(posedge clk)
    begin
        if (cmd.write && key_ok)
        begin
            step_reg[key_index[KEY_W-1:0]] <= step_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg        <= '0;
            phase_reg     <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            dwell_reg     <= DWELL_RESET;
            vol_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dwell_reg <= cfg_wdata;
            end
            if (cmd.write && key_ok)
            begin
                nz_reg[key_index[KEY_W-1:0]] <= (step_size != '0);
            end
            if (cmd.start)
            begin
                cnt_reg <= cnt_next;
                vol_reg <= volume;
                if (cnt_next == '0)
                begin
                    ptr_reg <= ptr_succ;
                end
            end
            if (cmd.advance)
            begin
                ptr_reg <= ptr_succ;
            end
            if (cmd.add)
            begin
                phase_reg <= phase_reg + step_reg[ptr_reg][PHASE_BITS-1:0];
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_reg <= {~scaled[SAMPLE_W-1], scaled[SAMPLE_W-2:0]};
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

endmodule

@@ src/arpeggio_phase_accumulator_top.sv @@
// Arpeggio phase accumulator, top level: controller plus datapath.
// A key write gives no result. A sample tick goes from idle to the key search, which walks
//   the table up to and including the first held key, and then to the finish state, which
//   loads the output register and raises out_valid once that register is free.
// A new tick is taken only in idle, after the search and finish of the last one.
// Reset (rst_n, async, active low): table empty, phase, pointer and divider zero,
//   dwell 25, no result pending. No clearing pass.
module arpeggio_phase_accumulator_top
    import arp_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input item channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [KEY_IDX_W-1:0] key_index,
    input  logic [STEP_W-1:0]    step_size,
    input  logic [VOL_W-1:0]     volume,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SAMPLE_W-1:0]  sample_out,
    // dwell_samples register write
    input  logic                 cfg_we,
    input  logic [DWELL_W-1:0]   cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // Controller: accept a transfer in idle, walk the key search, then hand
    // the sample to the output register once it is free.
    arp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: table, divider, pointer, accumulator and the output register
    // that lets the next item in while a result waits.
    arp_datapath #(
        .NUM_KEYS   (NUM_KEYS),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key_index  (key_index),
        .step_size  (step_size),
        .volume     (volume),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    // Add the step only for a held key
    a_add_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |-> (status.hit && status.any))
        else $error("phase add without a held key");

    // Never overwrite a result that has not been taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && !out_ready))
        else $error("output register overwritten");

    // Drop input ready while a tick is at work
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !in_ready)
        else $error("input accepted during a tick");

    // Advance the phase at most once per tick
    a_single_add: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |=> (!cmd.add && !cmd.advance))
        else $error("second search step after phase add");

endmodule
